// ===== hw/rtl/camera_triangle_project_assert.svh =====
// Assertion helpers shared by the RTL; expect clk and arst_n in scope.
`ifndef CAMERA_TRIANGLE_PROJECT_ASSERT_SVH
`define CAMERA_TRIANGLE_PROJECT_ASSERT_SVH

// Same-cycle implication.
`define CTP_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define CTP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/ctp_pkg.sv =====
package ctp_pkg;

	localparam int CRD_W   = 24;
	localparam int TRIG_W  = 16;
	localparam int FOC_W   = 24;
	localparam int CFG_W   = 24;
	localparam int OUT_W   = 27;
	localparam int DIF_W   = CRD_W + 1;
	localparam int R1_W    = 28;
	localparam int R2_W    = 30;
	localparam int MAG_W   = 28;
	localparam int PROD_W  = 45;
	localparam int P1_W    = DIF_W + TRIG_W;
	localparam int P2_W    = R1_W + TRIG_W;
	localparam int FRAC_B  = 14;
	localparam int FRAC_M  = (1 << FRAC_B) - 1;
	localparam int QUO_W   = 28;
	localparam int NUM_W   = MAG_W + FOC_W;
	localparam int DEN_W   = 37;
	localparam int SUM_W   = 31;
	localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;
	localparam int OUT_MIN = -(1 << (OUT_W - 1));
	localparam int REG_IDX_W = 3;

	localparam int NEAR_DEPTH_DEF = 2;
	localparam int FAR_DEPTH_DEF  = 3200;
	localparam int SCREEN_W_DEF   = 800;
	localparam int SCREEN_H_DEF   = 600;

	localparam int TRIG_ONE  = 16384;
	localparam int FOCAL_RST = 72425;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_CAM_X,
		REG_CAM_Y,
		REG_CAM_Z,
		REG_COS_YAW,
		REG_SIN_YAW,
		REG_COS_PITCH,
		REG_SIN_PITCH,
		REG_FOCAL
	} reg_idx_t;

	typedef struct packed {
		logic       vis;
		logic [2:0] neg_x;
		logic [2:0] neg_y;
	} side_t;

	// Signed divide by 2^14, truncating toward zero.
	function automatic logic signed [PROD_W-1:0] trunc_q14(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] bias;
		bias = v[PROD_W-1] ? PROD_W'(FRAC_M) : PROD_W'(0);
		return (v + bias) >>> FRAC_B;
	endfunction

	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
		logic signed [OUT_W-1:0] r;
		if (v > SUM_W'(OUT_MAX))
			r = OUT_W'(OUT_MAX);
		else if (v < SUM_W'(OUT_MIN))
			r = OUT_W'(OUT_MIN);
		else
			r = v[OUT_W-1:0];
		return r;
	endfunction

endpackage

// ===== hw/rtl/ctp_vtx_if.sv =====
interface ctp_vtx_if import ctp_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [CRD_W-1:0] a_x;
	logic signed [CRD_W-1:0] a_y;
	logic signed [CRD_W-1:0] a_z;
	logic signed [CRD_W-1:0] b_x;
	logic signed [CRD_W-1:0] b_y;
	logic signed [CRD_W-1:0] b_z;
	logic signed [CRD_W-1:0] c_x;
	logic signed [CRD_W-1:0] c_y;
	logic signed [CRD_W-1:0] c_z;

	modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, input ready);
	modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

// ===== hw/rtl/ctp_scr_if.sv =====
interface ctp_scr_if import ctp_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    visible;
	logic signed [OUT_W-1:0] sa_x;
	logic signed [OUT_W-1:0] sa_y;
	logic signed [OUT_W-1:0] sb_x;
	logic signed [OUT_W-1:0] sb_y;
	logic signed [OUT_W-1:0] sc_x;
	logic signed [OUT_W-1:0] sc_y;

	modport source (output valid, visible, sa_x, sa_y, sb_x, sb_y, sc_x, sc_y, input ready);
	modport sink (input valid, visible, sa_x, sa_y, sb_x, sb_y, sc_x, sc_y, output ready);
endinterface

// ===== hw/rtl/ctp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module ctp_div import ctp_pkg::*; #(
	parameter int NW = NUM_W,
	parameter int DW = DEN_W,
	parameter int QW = QUO_W
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	logic [DW-1:0] rem_s [QW];
	logic [QW-1:0] low_s [QW];
	logic [QW-1:0] q_s   [QW];
	logic [DW-1:0] den_s [QW];

	for (genvar g = 0; g < QW; g++) begin : g_step
		logic [DW-1:0] rem_in;
		logic [QW-1:0] low_in;
		logic [QW-1:0] q_in;
		logic [DW-1:0] den_in;
		logic [DW:0]   trial;
		logic [DW:0]   diff;

		if (g == 0) begin : g_first
			// upper dividend bits are below the divisor since the quotient fits QW bits
			assign rem_in = DW'(num[NW-1:QW]);
			assign low_in = num[QW-1:0];
			assign q_in   = '0;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_s[g-1];
			assign low_in = low_s[g-1];
			assign q_in   = q_s[g-1];
			assign den_in = den_s[g-1];
		end

		assign trial = {rem_in, low_in[QW-1]};
		assign diff  = trial - {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
				low_s[g] <= {low_in[QW-2:0], 1'b0};
				q_s[g]   <= {q_in[QW-2:0], ~diff[DW]};
				den_s[g] <= den_in;
			end
		end
	end

	assign quo = q_s[QW-1];

endmodule

// ===== hw/rtl/camera_triangle_project.sv =====
// Triangle perspective projection.
// Input channel "vertices" carries three world vertices a, b, c (24-bit signed).
// Output channel "screen" carries the visible flag and six 27-bit screen
// coordinates; a hidden triangle comes out with all coordinates zero.
// Both channels move a transaction when valid and ready are high together.
// Camera position, yaw/pitch sines and cosines (Q2.14) and focal length
// (Q16.8) are set through wr_en / wr_index / wr_data; write them only while
// no transaction is in flight.
// Pipeline: seven stages of subtract, rotate and multiply, 28 stages of the
// restoring divider (one quotient bit per stage), and the output register.
// Throughput: one triangle per cycle; all stages advance together.
// When the receiver stalls with a result pending, every stage holds and
// vertices.ready drops; nothing is lost or repeated.
// Reset clears the valid bits and loads the default camera registers.
`include "camera_triangle_project_assert.svh"

module camera_triangle_project import ctp_pkg::*; #(
	parameter int NEAR_DEPTH = NEAR_DEPTH_DEF,
	parameter int FAR_DEPTH  = FAR_DEPTH_DEF,
	parameter int SCREEN_W   = SCREEN_W_DEF,
	parameter int SCREEN_H   = SCREEN_H_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	ctp_vtx_if.sink              vertices,
	ctp_scr_if.source            screen
);

	localparam int ZC_W = MAG_W;
	localparam logic signed [SUM_W-1:0] HALF_W = SUM_W'(SCREEN_W / 2);
	localparam logic signed [SUM_W-1:0] HALF_H = SUM_W'(SCREEN_H / 2);
	localparam logic [DEN_W-1:0] DEN_MIN = DEN_W'(NEAR_DEPTH * 256);

	// configuration registers
	logic signed [CRD_W-1:0]  cam_x_q, cam_y_q, cam_z_q;
	logic signed [TRIG_W-1:0] cy_q, sy_q, cp_q, sp_q;
	logic [FOC_W-1:0]         focal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q <= '0;
			cam_y_q <= '0;
			cam_z_q <= '0;
			cy_q    <= TRIG_W'(TRIG_ONE);
			sy_q    <= '0;
			cp_q    <= TRIG_W'(TRIG_ONE);
			sp_q    <= '0;
			focal_q <= FOC_W'(FOCAL_RST);
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_CAM_X:     cam_x_q <= wr_data[CRD_W-1:0];
				REG_CAM_Y:     cam_y_q <= wr_data[CRD_W-1:0];
				REG_CAM_Z:     cam_z_q <= wr_data[CRD_W-1:0];
				REG_COS_YAW:   cy_q    <= wr_data[TRIG_W-1:0];
				REG_SIN_YAW:   sy_q    <= wr_data[TRIG_W-1:0];
				REG_COS_PITCH: cp_q    <= wr_data[TRIG_W-1:0];
				REG_SIN_PITCH: sp_q    <= wr_data[TRIG_W-1:0];
				REG_FOCAL:     focal_q <= wr_data[FOC_W-1:0];
				default: ;
			endcase
		end
	end

	// whole pipeline advances unless a result waits at the output
	logic ce;
	logic out_v_q;
	assign ce = !out_v_q || screen.ready;
	assign vertices.ready = ce;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic vd_s [QUO_W];

	logic signed [CRD_W-1:0] in_x [3];
	logic signed [CRD_W-1:0] in_y [3];
	logic signed [CRD_W-1:0] in_z [3];

	assign in_x[0] = vertices.a_x;
	assign in_y[0] = vertices.a_y;
	assign in_z[0] = vertices.a_z;
	assign in_x[1] = vertices.b_x;
	assign in_y[1] = vertices.b_y;
	assign in_z[1] = vertices.b_z;
	assign in_x[2] = vertices.c_x;
	assign in_y[2] = vertices.c_y;
	assign in_z[2] = vertices.c_z;

	logic signed [DIF_W-1:0] dx_s1 [3];
	logic signed [DIF_W-1:0] dy_s1 [3];
	logic signed [DIF_W-1:0] dz_s1 [3];

	logic signed [P1_W-1:0]  pxc_s2 [3];
	logic signed [P1_W-1:0]  pzs_s2 [3];
	logic signed [P1_W-1:0]  pzc_s2 [3];
	logic signed [P1_W-1:0]  pxs_s2 [3];
	logic signed [DIF_W-1:0] dy_s2  [3];

	logic signed [R1_W-1:0]  x1_s3 [3];
	logic signed [R1_W-1:0]  z1_s3 [3];
	logic signed [DIF_W-1:0] dy_s3 [3];

	logic signed [P1_W-1:0] pyc_s4 [3];
	logic signed [P2_W-1:0] pzs_s4 [3];
	logic signed [P2_W-1:0] pzc_s4 [3];
	logic signed [P1_W-1:0] pys_s4 [3];
	logic signed [R1_W-1:0] x1_s4  [3];

	logic signed [R1_W-1:0] x1_s5 [3];
	logic signed [R2_W-1:0] y2_s5 [3];
	logic signed [R2_W-1:0] z2_s5 [3];

	logic [MAG_W-1:0] mx_s6 [3];
	logic [MAG_W-1:0] my_s6 [3];
	logic [DEN_W-1:0] den_s6 [3];
	side_t            side_s6;

	logic [NUM_W-1:0] nx_s7 [3];
	logic [NUM_W-1:0] ny_s7 [3];
	logic [DEN_W-1:0] den_s7 [3];
	side_t            side_s7;

	side_t            sd_s [QUO_W];

	logic [QUO_W-1:0] qx [3];
	logic [QUO_W-1:0] qy [3];

	logic                    vis_q;
	logic signed [OUT_W-1:0] ox_q [3];
	logic signed [OUT_W-1:0] oy_q [3];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			v_s7    <= 1'b0;
			for (int i = 0; i < QUO_W; i++)
				vd_s[i] <= 1'b0;
			out_v_q <= 1'b0;
		end else if (ce) begin
			v_s1    <= vertices.valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			v_s6    <= v_s5;
			v_s7    <= v_s6;
			vd_s[0] <= v_s7;
			for (int i = 1; i < QUO_W; i++)
				vd_s[i] <= vd_s[i-1];
			out_v_q <= vd_s[QUO_W-1];
		end
	end

	// rotation front end
	logic signed [PROD_W-1:0] t_x3 [3];
	logic signed [PROD_W-1:0] t_z3 [3];
	logic signed [PROD_W-1:0] t_y5 [3];
	logic signed [PROD_W-1:0] t_z5 [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			t_x3[k] = trunc_q14(PROD_W'(pxc_s2[k]) - PROD_W'(pzs_s2[k]));
			t_z3[k] = trunc_q14(PROD_W'(pzc_s2[k]) + PROD_W'(pxs_s2[k]));
			t_y5[k] = trunc_q14(PROD_W'(pyc_s4[k]) - PROD_W'(pzs_s4[k]));
			t_z5[k] = trunc_q14(PROD_W'(pzc_s4[k]) + PROD_W'(pys_s4[k]));
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int k = 0; k < 3; k++) begin
				dx_s1[k]  <= DIF_W'(in_x[k]) - DIF_W'(cam_x_q);
				dy_s1[k]  <= DIF_W'(in_y[k]) - DIF_W'(cam_y_q);
				dz_s1[k]  <= DIF_W'(in_z[k]) - DIF_W'(cam_z_q);

				pxc_s2[k] <= dx_s1[k] * cy_q;
				pzs_s2[k] <= dz_s1[k] * sy_q;
				pzc_s2[k] <= dz_s1[k] * cy_q;
				pxs_s2[k] <= dx_s1[k] * sy_q;
				dy_s2[k]  <= dy_s1[k];

				x1_s3[k]  <= t_x3[k][R1_W-1:0];
				z1_s3[k]  <= t_z3[k][R1_W-1:0];
				dy_s3[k]  <= dy_s2[k];

				pyc_s4[k] <= dy_s3[k] * cp_q;
				pzs_s4[k] <= z1_s3[k] * sp_q;
				pzc_s4[k] <= z1_s3[k] * cp_q;
				pys_s4[k] <= dy_s3[k] * sp_q;
				x1_s4[k]  <= x1_s3[k];

				x1_s5[k]  <= x1_s4[k];
				y2_s5[k]  <= t_y5[k][R2_W-1:0];
				z2_s5[k]  <= t_z5[k][R2_W-1:0];
			end
		end
	end

	// depth test, clamp, divisor and magnitudes
	logic             below_far, above_near;
	logic [ZC_W-1:0]  zc6  [3];
	logic [MAG_W-1:0] mx6  [3];
	logic [MAG_W-1:0] my6  [3];
	logic [DEN_W-1:0] den6 [3];
	side_t            side6;

	always_comb begin
		below_far  = 1'b0;
		above_near = 1'b0;
		side6      = '0;
		for (int k = 0; k < 3; k++) begin
			if (z2_s5[k] < R2_W'(FAR_DEPTH))
				below_far = 1'b1;
			if (z2_s5[k] > R2_W'(NEAR_DEPTH))
				above_near = 1'b1;
			zc6[k]  = (z2_s5[k] < R2_W'(NEAR_DEPTH)) ? ZC_W'(NEAR_DEPTH) : z2_s5[k][ZC_W-1:0];
			den6[k] = DEN_W'({zc6[k], 8'b0}) + DEN_W'(focal_q);
			mx6[k]  = x1_s5[k][R1_W-1] ? MAG_W'(-x1_s5[k]) : MAG_W'(x1_s5[k]);
			my6[k]  = y2_s5[k][R2_W-1] ? MAG_W'(-y2_s5[k]) : MAG_W'(y2_s5[k]);
			side6.neg_x[k] = x1_s5[k][R1_W-1];
			side6.neg_y[k] = y2_s5[k][R2_W-1];
		end
		side6.vis = below_far && above_near;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int k = 0; k < 3; k++) begin
				mx_s6[k]  <= mx6[k];
				my_s6[k]  <= my6[k];
				den_s6[k] <= den6[k];
				nx_s7[k]  <= NUM_W'(mx_s6[k]) * NUM_W'(focal_q);
				ny_s7[k]  <= NUM_W'(my_s6[k]) * NUM_W'(focal_q);
				den_s7[k] <= den_s6[k];
			end
			side_s6 <= side6;
			side_s7 <= side_s6;
			sd_s[0] <= side_s7;
			for (int i = 1; i < QUO_W; i++)
				sd_s[i] <= sd_s[i-1];
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_vtx
		ctp_div #(
			.NW(NUM_W),
			.DW(DEN_W),
			.QW(QUO_W)
		) u_div_x (
			.clk(clk),
			.en (ce),
			.num(nx_s7[k]),
			.den(den_s7[k]),
			.quo(qx[k])
		);

		ctp_div #(
			.NW(NUM_W),
			.DW(DEN_W),
			.QW(QUO_W)
		) u_div_y (
			.clk(clk),
			.en (ce),
			.num(ny_s7[k]),
			.den(den_s7[k]),
			.quo(qy[k])
		);
	end

	// restore sign, center, saturate; hidden triangles drop to zero
	logic signed [SUM_W-1:0] sx [3];
	logic signed [SUM_W-1:0] sy [3];
	side_t                   sd_last;

	always_comb begin
		sd_last = sd_s[QUO_W-1];
		for (int k = 0; k < 3; k++) begin
			sx[k] = (sd_last.neg_x[k] ? -SUM_W'(qx[k]) : SUM_W'(qx[k])) + HALF_W;
			sy[k] = (sd_last.neg_y[k] ? -SUM_W'(qy[k]) : SUM_W'(qy[k])) + HALF_H;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			vis_q <= sd_last.vis;
			for (int k = 0; k < 3; k++) begin
				ox_q[k] <= sd_last.vis ? sat_out(sx[k]) : '0;
				oy_q[k] <= sd_last.vis ? sat_out(sy[k]) : '0;
			end
		end
	end

	assign screen.valid   = out_v_q;
	assign screen.visible = vis_q;
	assign screen.sa_x    = ox_q[0];
	assign screen.sa_y    = oy_q[0];
	assign screen.sb_x    = ox_q[1];
	assign screen.sb_y    = oy_q[1];
	assign screen.sc_x    = ox_q[2];
	assign screen.sc_y    = oy_q[2];

	`CTP_ASSERT_SAME(a_hidden_zero, screen.valid && !screen.visible, screen.sa_x == '0 && screen.sa_y == '0 && screen.sb_x == '0 && screen.sb_y == '0 && screen.sc_x == '0 && screen.sc_y == '0)
	`CTP_ASSERT_NEXT(a_front_advance, v_s1 && ce, v_s2)
	`CTP_ASSERT_SAME(a_den_floor, v_s7, den_s7[0] >= DEN_MIN && den_s7[1] >= DEN_MIN && den_s7[2] >= DEN_MIN)

endmodule
